/* src/safbu_pkg.sv */
`default_nettype none

package safbu_pkg;

   // Operation requested by an input word.
   localparam logic [2:0] REQ_MOVE    = 3'd0;
   localparam logic [2:0] REQ_COMPARE = 3'd1;
   localparam logic [2:0] REQ_ADD     = 3'd2;
   localparam logic [2:0] REQ_SUB     = 3'd3;
   localparam logic [2:0] REQ_BRANCH  = 3'd4;

   // Operand size.
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_WORD = 2'd1;
   localparam logic [1:0] SIZE_LONG = 2'd2;

   // Branch condition codes.
   localparam logic [3:0] COND_VS = 4'd0;
   localparam logic [3:0] COND_VC = 4'd1;
   localparam logic [3:0] COND_CS = 4'd2;
   localparam logic [3:0] COND_CC = 4'd3;
   localparam logic [3:0] COND_EQ = 4'd4;
   localparam logic [3:0] COND_NE = 4'd5;
   localparam logic [3:0] COND_LS = 4'd6;
   localparam logic [3:0] COND_HI = 4'd7;
   localparam logic [3:0] COND_MI = 4'd8;
   localparam logic [3:0] COND_PL = 4'd9;
   localparam logic [3:0] COND_AL = 4'd10;
   localparam logic [3:0] COND_RSV = 4'd11;
   localparam logic [3:0] COND_LT = 4'd12;
   localparam logic [3:0] COND_GE = 4'd13;
   localparam logic [3:0] COND_LE = 4'd14;
   localparam logic [3:0] COND_GT = 4'd15;

   // Fall-through lengths of narrow and wide branches.
   localparam logic [31:0] BRANCH_LEN_NARROW = 32'd2;
   localparam logic [31:0] BRANCH_LEN_WIDE   = 32'd3;

   localparam int REQ_TDATA_W = 120;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_BITS    = 71;
   localparam int RSP_TDATA_W = 72;

   typedef struct packed {
      logic sign;
      logic zero;
      logic overflow;
      logic carry;
   } flags_type;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [1:0]         op_size;
      logic [31:0]        src_value;
      logic [31:0]        dst_value;
      logic [3:0]         cond_code;
      logic               branch_wide;
      logic [31:0]        branch_address;
      logic signed [15:0] branch_disp;
   } item_type;

   // Packed so that result_value sits in the lowest bits, as on rsp_tdata.
   typedef struct packed {
      logic        bad_condition;
      logic [31:0] next_address;
      logic        branch_taken;
      logic        sign_flag;
      logic        zero_flag;
      logic        overflow_flag;
      logic        carry_flag;
      logic        write_enable;
      logic [31:0] result_value;
   } result_type;

endpackage

`default_nettype wire

/* src/safbu_exec.sv */
`default_nettype none

module safbu_exec
   import safbu_pkg::*;
(
   input  item_type   item,
   input  flags_type  flags,
   output result_type result,
   output flags_type  flags_next
);

   logic [31:0] mask;
   logic [31:0] s_m;
   logic [31:0] d_m;
   logic [32:0] sum;
   logic [32:0] diff;
   logic [31:0] r_arith;
   logic        is_sub;
   logic        carry;
   logic        s_sign;
   logic        d_sign;
   logic        r_sign;
   logic        ovf;
   logic        cond_ok;
   logic        lt;
   logic [31:0] disp;
   logic [31:0] fall_len;
   flags_type   arith_flags;

   always_comb begin
      case (item.op_size)
         SIZE_BYTE: mask = 32'h0000_00ff;
         SIZE_WORD: mask = 32'h0000_ffff;
         default:   mask = 32'hffff_ffff;
      endcase
   end

   assign s_m    = item.src_value & mask;
   assign d_m    = item.dst_value & mask;
   assign is_sub = (item.req_type != REQ_ADD);
   assign sum    = {1'b0, d_m} + {1'b0, s_m};
   assign diff   = {1'b0, d_m} - {1'b0, s_m};
   assign r_arith = (is_sub ? diff[31:0] : sum[31:0]) & mask;

   always_comb begin
      case (item.op_size)
         SIZE_BYTE: begin
            s_sign = s_m[7];
            d_sign = d_m[7];
            r_sign = r_arith[7];
            carry  = is_sub ? diff[32] : sum[8];
         end
         SIZE_WORD: begin
            s_sign = s_m[15];
            d_sign = d_m[15];
            r_sign = r_arith[15];
            carry  = is_sub ? diff[32] : sum[16];
         end
         default: begin
            s_sign = s_m[31];
            d_sign = d_m[31];
            r_sign = r_arith[31];
            carry  = is_sub ? diff[32] : sum[32];
         end
      endcase
   end

   // Subtract overflows when the operands differ in sign and the result
   // takes the sign of the subtrahend; add when both operands differ from it.
   assign ovf = is_sub ? ((d_sign ^ s_sign) & (d_sign ^ r_sign))
                       : ((r_sign ^ s_sign) & (r_sign ^ d_sign));

   assign arith_flags.carry    = carry;
   assign arith_flags.overflow = ovf;
   assign arith_flags.zero     = (r_arith == 32'd0);
   assign arith_flags.sign     = r_sign;

   assign lt = flags.sign ^ flags.overflow;

   always_comb begin
      case (item.cond_code)
         COND_VS: cond_ok = flags.overflow;
         COND_VC: cond_ok = !flags.overflow;
         COND_CS: cond_ok = flags.carry;
         COND_CC: cond_ok = !flags.carry;
         COND_EQ: cond_ok = flags.zero;
         COND_NE: cond_ok = !flags.zero;
         COND_LS: cond_ok = flags.carry | flags.zero;
         COND_HI: cond_ok = !(flags.carry | flags.zero);
         COND_MI: cond_ok = flags.sign;
         COND_PL: cond_ok = !flags.sign;
         COND_AL: cond_ok = 1'b1;
         COND_LT: cond_ok = lt;
         COND_GE: cond_ok = !lt;
         COND_LE: cond_ok = lt | flags.zero;
         COND_GT: cond_ok = !(lt | flags.zero);
         default: cond_ok = 1'b0;
      endcase
   end

   assign disp = item.branch_wide ? {{16{item.branch_disp[15]}}, item.branch_disp}
                                  : {{24{item.branch_disp[7]}}, item.branch_disp[7:0]};
   assign fall_len = item.branch_wide ? BRANCH_LEN_WIDE : BRANCH_LEN_NARROW;

   always_comb begin
      result               = '0;
      flags_next           = flags;
      case (item.req_type)
         REQ_MOVE: begin
            result.result_value = s_m;
            result.write_enable = 1'b1;
         end
         REQ_COMPARE: begin
            flags_next = arith_flags;
         end
         REQ_ADD, REQ_SUB: begin
            result.result_value = r_arith;
            result.write_enable = 1'b1;
            flags_next          = arith_flags;
         end
         REQ_BRANCH: begin
            result.bad_condition = (item.cond_code == COND_RSV);
            result.branch_taken  = cond_ok;
            result.next_address  = item.branch_address + (cond_ok ? disp : fall_len);
         end
         default: begin
            result = '0;
         end
      endcase
      result.carry_flag    = flags_next.carry;
      result.overflow_flag = flags_next.overflow;
      result.zero_flag     = flags_next.zero;
      result.sign_flag     = flags_next.sign;
   end

endmodule

`default_nettype wire

/* src/sized_alu_flags_branch_unit.sv */
`default_nettype none

// Execute stage with carry, overflow, zero and sign flags. Each input word
// carries one operation (move, compare, add, subtract or conditional branch)
// on byte, word or long operands; each gives exactly one result word with
// the sized result, the flags after the operation and, for a branch, the
// taken bit and next address. An accepted word sits in an input register,
// is evaluated against the current flags and lands in the result register;
// one word can enter every cycle while the result side takes its words.
// The flag register is updated as a word moves into the result register,
// which keeps each branch test in order behind the arithmetic before it.
// Flags clear at reset; reserved condition code 11 raises bad_condition.

module sized_alu_flags_branch_unit
   import safbu_pkg::*;
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   // [31:0] src_value, [63:32] dst_value, [67:64] cond_code,
   // [68] branch_wide, [100:69] branch_address, [116:101] branch_disp
   input  wire  [REQ_TDATA_W-1:0]  req_tdata,
   // [2:0] req_type, [4:3] op_size
   input  wire  [REQ_TUSER_W-1:0]  req_tuser,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   // [31:0] result_value, [32] write_enable, [33] carry_flag,
   // [34] overflow_flag, [35] zero_flag, [36] sign_flag, [37] branch_taken,
   // [69:38] next_address, [70] bad_condition
   output logic [RSP_TDATA_W-1:0]  rsp_tdata
);

   logic       in_valid_ff;
   logic       in_valid_in;
   item_type   item_ff;
   item_type   item_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type result_ff;
   result_type result_in;
   flags_type  flags_ff;
   flags_type  flags_in;
   flags_type  flags_next;
   logic       advance;
   logic       req_fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign item_in.req_type       = req_tuser[2:0];
   assign item_in.op_size        = req_tuser[4:3];
   assign item_in.src_value      = req_tdata[31:0];
   assign item_in.dst_value      = req_tdata[63:32];
   assign item_in.cond_code      = req_tdata[67:64];
   assign item_in.branch_wide    = req_tdata[68];
   assign item_in.branch_address = req_tdata[100:69];
   assign item_in.branch_disp    = req_tdata[116:101];

   safbu_exec u_exec (
      .item       (item_ff),
      .flags      (flags_ff),
      .result     (result_in),
      .flags_next (flags_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      flags_in = advance ? flags_next : flags_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         flags_ff     <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_BITS){1'b0}}, result_ff};

endmodule

`default_nettype wire

/* src/safbu_checker.sv */
`default_nettype none

module safbu_checker
   import safbu_pkg::*;
(
   input wire                    clock,
   input wire                    reset,
   input wire                    req_tvalid,
   input wire                    req_tready,
   input wire                    rsp_tvalid,
   input wire                    rsp_tready,
   input wire [RSP_TDATA_W-1:0]  rsp_tdata
);

   result_type rsp;

   assign rsp = result_type'(rsp_tdata[RSP_BITS-1:0]);

   // No result word may appear in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed or dropped");

   // A reserved condition never branches.
   a_bad_not_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.bad_condition |-> !rsp.branch_taken && !rsp.write_enable)
      else $error("reserved condition reported as taken or writing");

   // Words that write a result are not branches.
   a_write_no_branch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.write_enable |-> rsp.next_address == 32'd0
      && !rsp.branch_taken)
      else $error("writing word carries branch information");

   // A result word that appears needs an input word accepted before it.
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2)
      || $past(req_tvalid && req_tready, 1))
      else $error("result word without an accepted input word");

endmodule

bind sized_alu_flags_branch_unit safbu_checker u_safbu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* tb/alu_result_checker.sv */
`timescale 1ns / 1ps

module alu_result_checker
   import safbu_pkg::*;
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   input  wire                    req_tready,
   // [31:0] src_value, [63:32] dst_value, [67:64] cond_code,
   // [68] branch_wide, [100:69] branch_address, [116:101] branch_disp
   input  wire  [REQ_TDATA_W-1:0] req_tdata,
   // [2:0] req_type, [4:3] op_size
   input  wire  [REQ_TUSER_W-1:0] req_tuser,
   input  wire                    rsp_tvalid,
   input  wire                    rsp_tready,
   // [31:0] result_value, [32] write_enable, [33] carry_flag,
   // [34] overflow_flag, [35] zero_flag, [36] sign_flag, [37] branch_taken,
   // [69:38] next_address, [70] bad_condition
   input  wire  [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     fail_count,
   output int                     pending,
   output int                     checked
);

   flags_type  flags_now;
   result_type predicted_results[$];
   int         errors = 0;
   int         n_checked = 0;

   function automatic logic [31:0] width_mask(logic [1:0] size);
      case (size)
         SIZE_BYTE: return 32'h0000_00ff;
         SIZE_WORD: return 32'h0000_ffff;
         default:   return 32'hffff_ffff;
      endcase
   endfunction

   function automatic logic [31:0] width_sign(logic [1:0] size);
      case (size)
         SIZE_BYTE: return 32'h0000_0080;
         SIZE_WORD: return 32'h0000_8000;
         default:   return 32'h8000_0000;
      endcase
   endfunction

   // Works out the result word of one operation from the flags left by the
   // previous one. The flag fields of the result are the new flag state.
   function automatic result_type execute_word(item_type it, flags_type fl);
      result_type  r;
      logic [31:0] m, sb, s, d, sized, disp32;
      logic [32:0] sum;
      logic        hold;
      r = '0;
      r.carry_flag = fl.carry;
      r.overflow_flag = fl.overflow;
      r.zero_flag = fl.zero;
      r.sign_flag = fl.sign;
      m = width_mask(it.op_size);
      sb = width_sign(it.op_size);
      s = it.src_value & m;
      d = it.dst_value & m;
      case (it.req_type)
         REQ_MOVE: begin
            r.result_value = s;
            r.write_enable = 1'b1;
         end
         REQ_COMPARE, REQ_SUB: begin
            sized = (d - s) & m;
            r.carry_flag = d < s;
            r.overflow_flag = |((d ^ s) & (d ^ sized) & sb);
            r.zero_flag = sized == 32'd0;
            r.sign_flag = |(sized & sb);
            if (it.req_type == REQ_SUB) begin
               r.result_value = sized;
               r.write_enable = 1'b1;
            end
         end
         REQ_ADD: begin
            sum = {1'b0, d} + {1'b0, s};
            sized = sum[31:0] & m;
            r.carry_flag = sum > {1'b0, m};
            r.overflow_flag = |((sized ^ s) & (sized ^ d) & sb);
            r.zero_flag = sized == 32'd0;
            r.sign_flag = |(sized & sb);
            r.result_value = sized;
            r.write_enable = 1'b1;
         end
         REQ_BRANCH: begin
            if (it.branch_wide)
               disp32 = {{16{it.branch_disp[15]}}, it.branch_disp};
            else
               disp32 = {{24{it.branch_disp[7]}}, it.branch_disp[7:0]};
            case (it.cond_code)
               COND_VS: hold = fl.overflow;
               COND_VC: hold = !fl.overflow;
               COND_CS: hold = fl.carry;
               COND_CC: hold = !fl.carry;
               COND_EQ: hold = fl.zero;
               COND_NE: hold = !fl.zero;
               COND_LS: hold = fl.carry || fl.zero;
               COND_HI: hold = !(fl.carry || fl.zero);
               COND_MI: hold = fl.sign;
               COND_PL: hold = !fl.sign;
               COND_AL: hold = 1'b1;
               COND_LT: hold = fl.sign != fl.overflow;
               COND_GE: hold = fl.sign == fl.overflow;
               COND_LE: hold = (fl.sign != fl.overflow) || fl.zero;
               COND_GT: hold = !((fl.sign != fl.overflow) || fl.zero);
               default: hold = 1'b0;
            endcase
            if (it.cond_code == COND_RSV)
               r.bad_condition = 1'b1;
            else
               r.branch_taken = hold;
            if (r.branch_taken)
               r.next_address = it.branch_address + disp32;
            else
               r.next_address = it.branch_address +
                  (it.branch_wide ? BRANCH_LEN_WIDE : BRANCH_LEN_NARROW);
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t %s mismatch: expected %h, got %h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      item_type   it;
      result_type want, got;
      if (reset) begin
         flags_now = '0;
         predicted_results.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            it.src_value = req_tdata[31:0];
            it.dst_value = req_tdata[63:32];
            it.cond_code = req_tdata[67:64];
            it.branch_wide = req_tdata[68];
            it.branch_address = req_tdata[100:69];
            it.branch_disp = req_tdata[116:101];
            it.req_type = req_tuser[2:0];
            it.op_size = req_tuser[4:3];
            want = execute_word(it, flags_now);
            flags_now = {want.sign_flag, want.zero_flag, want.overflow_flag,
                         want.carry_flag};
            predicted_results.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RSP_BITS-1:0]);
            if (predicted_results.size() == 0) begin
               $display("%0t result word with nothing expected: expected none, got %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               want = predicted_results.pop_front();
               compare_field("result_value", want.result_value, got.result_value);
               compare_field("write_enable", 32'(want.write_enable),
                             32'(got.write_enable));
               compare_field("carry_flag", 32'(want.carry_flag), 32'(got.carry_flag));
               compare_field("overflow_flag", 32'(want.overflow_flag),
                             32'(got.overflow_flag));
               compare_field("zero_flag", 32'(want.zero_flag), 32'(got.zero_flag));
               compare_field("sign_flag", 32'(want.sign_flag), 32'(got.sign_flag));
               compare_field("branch_taken", 32'(want.branch_taken),
                             32'(got.branch_taken));
               compare_field("next_address", want.next_address, got.next_address);
               compare_field("bad_condition", 32'(want.bad_condition),
                             32'(got.bad_condition));
               n_checked++;
            end
         end
      end
      fail_count <= errors;
      pending <= predicted_results.size();
      checked <= n_checked;
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import safbu_pkg::*;

   localparam int          RANDOM_WORDS = 1300;
   localparam int          QUIET_WORDS = 200;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          HOLD_CYCLES = 300;
   // Size code three behaves as long; request codes five to seven do nothing.
   localparam logic [1:0]  SIZE_SPARE = 2'd3;
   localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0]  REQ_UNUSED_MID = 3'd6;
   localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tready = 1'b0;
   wire                    req_tready;
   wire                    rsp_tvalid;
   wire  [RSP_TDATA_W-1:0] rsp_tdata;
   int                     fail_count;
   int                     pending;
   int                     checked;
   int                     cycle_count = 0;
   int                     words_sent = 0;
   bit                     quiet = 1'b0;
   bit                     long_hold = 1'b0;

   sized_alu_flags_branch_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   alu_result_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, pending);
         $display("FAIL");
         $finish;
      end
   end

   // Result side: random ready bursts, one long hold-off on request, and
   // always ready once the run goes quiet.
   initial begin
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
      end
   end

   function automatic item_type make_item(logic [2:0] kind, logic [1:0] size,
                                          logic [31:0] src, logic [31:0] dst,
                                          logic [3:0] cc, logic wide,
                                          logic [31:0] addr, logic [15:0] disp);
      item_type it;
      it.req_type = kind;
      it.op_size = size;
      it.src_value = src;
      it.dst_value = dst;
      it.cond_code = cc;
      it.branch_wide = wide;
      it.branch_address = addr;
      it.branch_disp = disp;
      return it;
   endfunction

   // Operands lean toward the size boundaries where carry and overflow flip.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hffff_ffff;
         2: begin
            case ($urandom_range(0, 7))
               0: return 32'h0000_007f;
               1: return 32'h0000_0080;
               2: return 32'h0000_00ff;
               3: return 32'h0000_7fff;
               4: return 32'h0000_8000;
               5: return 32'h0000_ffff;
               6: return 32'h7fff_ffff;
               default: return 32'h8000_0000;
            endcase
         end
         3: return 32'($urandom_range(0, 3));
         4: return ~32'($urandom_range(0, 3));
         default: return $urandom();
      endcase
   endfunction

   function automatic item_type random_word();
      item_type it;
      int       pick;
      pick = $urandom_range(0, 99);
      if (pick < 17)
         it.req_type = REQ_MOVE;
      else if (pick < 34)
         it.req_type = REQ_COMPARE;
      else if (pick < 53)
         it.req_type = REQ_ADD;
      else if (pick < 72)
         it.req_type = REQ_SUB;
      else if (pick < 97)
         it.req_type = REQ_BRANCH;
      else
         it.req_type = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      if ($urandom_range(0, 15) == 0)
         it.op_size = SIZE_SPARE;
      else
         it.op_size = 2'($urandom_range(SIZE_BYTE, SIZE_LONG));
      it.src_value = pick_operand();
      it.dst_value = ($urandom_range(0, 7) == 0) ? it.src_value : pick_operand();
      it.cond_code = 4'($urandom_range(0, 15));
      it.branch_wide = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
         0: it.branch_address = 32'hffff_fff0 + 32'($urandom_range(0, 15));
         1: it.branch_address = 32'($urandom_range(0, 15));
         default: it.branch_address = $urandom();
      endcase
      it.branch_disp = 16'($urandom());
      return it;
   endfunction

   task automatic send_word(input item_type it);
      req_tdata <= {3'b000, it.branch_disp, it.branch_address, it.branch_wide,
                    it.cond_code, it.dst_value, it.src_value};
      req_tuser <= {it.op_size, it.req_type};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic idle_gap(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin : stimulus
      item_type it;
      int       ops_done;
      bit       hold_started;
      bit       pause_done;
      ops_done = 0;
      hold_started = 1'b0;
      pause_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words: size extremes, carry and overflow edges, every
      // operation, unknown requests, the reserved condition and address wrap.
      send_word(make_item(REQ_MOVE, SIZE_BYTE, 32'hffff_ffff, 32'h0, COND_VS, 1'b0,
                          32'h0, 16'h0));
      send_word(make_item(REQ_MOVE, SIZE_SPARE, 32'h1234_5678, 32'hdead_beef,
                          COND_VC, 1'b1, 32'hffff_ffff, 16'hffff));
      send_word(make_item(REQ_ADD, SIZE_BYTE, 32'h0000_0001, 32'h0000_00ff, COND_CS,
                          1'b0, 32'h0, 16'h0));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_CS, 1'b0,
                          32'h0000_1000, 16'h0080));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_EQ, 1'b1,
                          32'hffff_fffe, 16'h0004));
      send_word(make_item(REQ_ADD, SIZE_BYTE, 32'h0000_0001, 32'h0000_007f, COND_VS,
                          1'b0, 32'h0, 16'h0));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_VS, 1'b0,
                          32'h0, 16'hff7f));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_LT, 1'b0,
                          32'hffff_ffff, 16'h0010));
      send_word(make_item(REQ_ADD, SIZE_LONG, 32'h0000_0001, 32'hffff_ffff, COND_VS,
                          1'b0, 32'h0, 16'h0));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_LS, 1'b1,
                          32'h0000_0010, 16'h8000));
      send_word(make_item(REQ_ADD, SIZE_WORD, 32'h0000_ffff, 32'hffff_ffff, COND_VS,
                          1'b0, 32'h0, 16'h0));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_MI, 1'b0,
                          32'h0000_0000, 16'h00fe));
      send_word(make_item(REQ_SUB, SIZE_BYTE, 32'h0000_0001, 32'h0000_0000, COND_VS,
                          1'b0, 32'h0, 16'h0));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_HI, 1'b0,
                          32'h8000_0000, 16'h0040));
      send_word(make_item(REQ_SUB, SIZE_LONG, 32'h0000_0001, 32'h8000_0000, COND_VS,
                          1'b0, 32'h0, 16'h0));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_GE, 1'b1,
                          32'hffff_fffe, 16'h7fff));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_GT, 1'b1,
                          32'h0000_2000, 16'h7fff));
      send_word(make_item(REQ_COMPARE, SIZE_WORD, 32'h0001_0005, 32'h0000_0005,
                          COND_VS, 1'b0, 32'h0, 16'h0));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_RSV, 1'b0,
                          32'h0000_0100, 16'h0020));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_RSV, 1'b1,
                          32'hffff_fffd, 16'h0020));
      send_word(make_item(REQ_ADD, SIZE_SPARE, 32'h8000_0000, 32'h8000_0000, COND_VS,
                          1'b0, 32'h0, 16'h0));
      send_word(make_item(REQ_UNUSED_LO, SIZE_LONG, 32'hffff_ffff, 32'hffff_ffff,
                          COND_AL, 1'b1, 32'hffff_ffff, 16'hffff));
      send_word(make_item(REQ_UNUSED_MID, SIZE_BYTE, 32'h0, 32'h1, COND_AL, 1'b0,
                          32'h1234_5678, 16'h1234));
      send_word(make_item(REQ_UNUSED_HI, SIZE_SPARE, 32'h5a5a_5a5a, 32'ha5a5_a5a5,
                          COND_RSV, 1'b1, 32'h0, 16'h0));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_LE, 1'b0,
                          32'h0000_0004, 16'h0081));
      send_word(make_item(REQ_BRANCH, SIZE_BYTE, 32'h0, 32'h0, COND_AL, 1'b1,
                          32'h0000_0004, 16'h8000));

      while (ops_done < RANDOM_WORDS) begin
         if (!hold_started && ops_done >= 300) begin
            // The result side holds off while words keep coming, so the
            // block fills up and has to stall its input.
            long_hold = 1'b1;
            hold_started = 1'b1;
         end
         if (!pause_done && ops_done >= 700) begin
            idle_gap(1);
            wait_drained();
            pause_done = 1'b1;
         end
         if (!quiet && !long_hold && $urandom_range(0, 3) == 0)
            idle_gap($urandom_range(1, 19));
         it = random_word();
         send_word(it);
         if (it.req_type <= REQ_BRANCH)
            ops_done++;
         quiet = ops_done >= RANDOM_WORDS - QUIET_WORDS;
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d words and checked %0d results: move, compare, add, subtract,",
               words_sent, checked);
      $display("branches on all condition codes, unknown requests, every operand size.");
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

/* sim.f */
src/safbu_pkg.sv
src/safbu_exec.sv
src/sized_alu_flags_branch_unit.sv
src/safbu_checker.sv
tb/alu_result_checker.sv
tb/testbench.sv
